[hdl/length_prefixed_frame_reassembler_macros.svh]
// assertion helpers for the frame reassembler
// all of them sample on clk and are held off while rst is high
`ifndef LENGTH_PREFIXED_FRAME_REASSEMBLER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_REASSEMBLER_MACROS_SVH

// expression must never be true
`define LPFR_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("lpfr: forbidden condition seen");

// antecedent implies consequent in the same cycle
`define LPFR_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpfr: same-cycle implication failed");

// antecedent implies consequent in the next cycle
`define LPFR_ASSERT_IMPLIES_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpfr: next-cycle implication failed");

`endif

[hdl/lpfr_pkg.sv]
`timescale 1ns / 1ps

package lpfr_pkg;

  // default payload store size in bytes
  localparam int STORE_DEPTH_DEF = 512;

  // request kinds
  localparam logic [1:0] KIND_BYTE       = 2'd0;
  localparam logic [1:0] KIND_LINK_RESET = 2'd1;
  localparam logic [1:0] KIND_READ       = 2'd2;

  // result kinds
  localparam logic [1:0] RK_DONE     = 2'd0;
  localparam logic [1:0] RK_OVERSIZE = 2'd1;
  localparam logic [1:0] RK_READ     = 2'd2;

  // header byte positions
  localparam logic [1:0] HDR_CMD    = 2'd0;
  localparam logic [1:0] HDR_LEN_LO = 2'd1;
  localparam logic [1:0] HDR_LEN_HI = 2'd2;

  // depth of the result queue
  localparam int RESQ_DEPTH = 3;

  // result control handed from the parser stage to the queue
  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic       oob;
  } res_ctl_t;

endpackage

[hdl/lpfr_ram.sv]
`timescale 1ns / 1ps

module lpfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/lpfr_ctrl.sv]
`timescale 1ns / 1ps

module lpfr_ctrl #(
  parameter int STORE_DEPTH = lpfr_pkg::STORE_DEPTH_DEF,
  parameter int AW = $clog2(STORE_DEPTH),
  parameter int LW = $clog2(STORE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               acc,
  input  logic [1:0]         kind,
  input  logic [7:0]         data_byte,
  input  logic               packet_end,
  input  logic [AW-1:0]      read_index,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic               rd_en,
  output lpfr_pkg::res_ctl_t p_ctl,
  output logic [7:0]         p_command,
  output logic [LW-1:0]      p_length
);

  localparam logic [15:0] DEPTH16 = 16'(STORE_DEPTH);
  localparam logic [AW:0] DEPTH_AW = (AW + 1)'(STORE_DEPTH);

  logic          frame_active, frame_active_next;
  logic [1:0]    header_count, header_count_next;
  logic          skip, skip_next;
  logic [7:0]    command_byte, command_byte_next;
  logic [7:0]    length_low, length_low_next;
  logic [LW-1:0] expected_length, expected_length_next;
  logic [LW-1:0] write_position, write_position_next;

  lpfr_pkg::res_ctl_t res;
  logic [7:0]         res_cmd;
  logic [LW-1:0]      res_len;
  logic [15:0]        len16;
  logic [LW-1:0]      wp_inc;
  logic               oob;

  assign len16   = {data_byte, length_low};
  assign wp_inc  = write_position + LW'(1);
  assign oob     = {1'b0, read_index} >= DEPTH_AW;
  assign wr_addr = write_position[AW-1:0];

  // frame parser: next state and result for the accepted request
  always_comb begin
    frame_active_next    = frame_active;
    header_count_next    = header_count;
    skip_next            = skip;
    command_byte_next    = command_byte;
    length_low_next      = length_low;
    expected_length_next = expected_length;
    write_position_next  = write_position;
    wr_en                = 1'b0;
    rd_en                = 1'b0;
    res                  = '0;
    res_cmd              = command_byte;
    res_len              = '0;
    if (acc) begin
      unique case (kind)
        lpfr_pkg::KIND_BYTE: begin
          if (frame_active) begin
            // payload byte goes to the store
            wr_en               = 1'b1;
            write_position_next = wp_inc;
            if (wp_inc >= expected_length) begin
              res.vld              = 1'b1;
              res.kind             = lpfr_pkg::RK_DONE;
              res_len              = expected_length;
              frame_active_next    = 1'b0;
              write_position_next  = '0;
              expected_length_next = '0;
              skip_next            = !packet_end;
            end
          end else if (skip) begin
            if (packet_end) begin
              skip_next = 1'b0;
            end
          end else begin
            case (header_count)
              lpfr_pkg::HDR_CMD: begin
                command_byte_next = data_byte;
                header_count_next = packet_end ? lpfr_pkg::HDR_CMD : lpfr_pkg::HDR_LEN_LO;
              end
              lpfr_pkg::HDR_LEN_LO: begin
                length_low_next   = data_byte;
                header_count_next = packet_end ? lpfr_pkg::HDR_CMD : lpfr_pkg::HDR_LEN_HI;
              end
              default: begin
                // length high byte closes the header
                header_count_next = lpfr_pkg::HDR_CMD;
                if (len16 == 16'd0) begin
                  res.vld              = 1'b1;
                  res.kind             = lpfr_pkg::RK_DONE;
                  expected_length_next = '0;
                  skip_next            = !packet_end;
                end else if (len16 > DEPTH16) begin
                  res.vld              = 1'b1;
                  res.kind             = lpfr_pkg::RK_OVERSIZE;
                  expected_length_next = '0;
                  skip_next            = !packet_end;
                end else begin
                  expected_length_next = len16[LW-1:0];
                  write_position_next  = '0;
                  frame_active_next    = 1'b1;
                end
              end
            endcase
          end
        end
        lpfr_pkg::KIND_LINK_RESET: begin
          frame_active_next   = 1'b0;
          header_count_next   = lpfr_pkg::HDR_CMD;
          skip_next           = 1'b0;
          write_position_next = '0;
        end
        lpfr_pkg::KIND_READ: begin
          rd_en    = !oob;
          res.vld  = 1'b1;
          res.kind = lpfr_pkg::RK_READ;
          res.oob  = oob;
          res_cmd  = 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active    <= 1'b0;
      header_count    <= lpfr_pkg::HDR_CMD;
      skip            <= 1'b0;
      expected_length <= '0;
      write_position  <= '0;
    end else begin
      frame_active    <= frame_active_next;
      header_count    <= header_count_next;
      skip            <= skip_next;
      expected_length <= expected_length_next;
      write_position  <= write_position_next;
    end
    command_byte <= command_byte_next;
    length_low   <= length_low_next;
  end

  // result stage, lines up with the store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl <= '0;
    end else begin
      p_ctl <= res;
    end
    p_command <= res_cmd;
    p_length  <= res_len;
  end

endmodule

[hdl/lpfr_resq.sv]
`timescale 1ns / 1ps

module lpfr_resq #(
  parameter int LW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [1:0]    push_kind,
  input  logic [7:0]    push_command,
  input  logic [LW-1:0] push_length,
  input  logic [7:0]    push_data,
  output logic [1:0]    count,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    result_kind,
  output logic [7:0]    command,
  output logic [LW-1:0] frame_length,
  output logic [7:0]    read_data
);

  localparam int PW = $clog2(lpfr_pkg::RESQ_DEPTH);
  localparam logic [PW-1:0] LAST = PW'(lpfr_pkg::RESQ_DEPTH - 1);

  logic [1:0]    kind_q [lpfr_pkg::RESQ_DEPTH];
  logic [7:0]    cmd_q  [lpfr_pkg::RESQ_DEPTH];
  logic [LW-1:0] len_q  [lpfr_pkg::RESQ_DEPTH];
  logic [7:0]    data_q [lpfr_pkg::RESQ_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic          pop;

  assign out_valid    = count != 2'd0;
  assign pop          = out_valid && out_ready;
  assign result_kind  = kind_q[rd_ptr];
  assign command      = cmd_q[rd_ptr];
  assign frame_length = len_q[rd_ptr];
  assign read_data    = data_q[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      kind_q[wr_ptr] <= push_kind;
      cmd_q[wr_ptr]  <= push_command;
      len_q[wr_ptr]  <= push_length;
      data_q[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

[hdl/length_prefixed_frame_reassembler.sv]
`timescale 1ns / 1ps
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------------
// in       | in_valid / in_ready  | kind, data_byte, packet_end, read_index
// out      | out_valid / out_ready| result_kind, command, frame_length, read_data
//
// one request per cycle while in_ready is high; a result passes the result stage register, then the queue
// the payload store read is registered alongside the result stage register
// a three-entry result queue takes new requests while results wait
// in_ready drops only when the queue plus the result in flight hold three
// rst is synchronous; the store holds no reset and needs no clearing pass

`include "length_prefixed_frame_reassembler_macros.svh"

module length_prefixed_frame_reassembler #(
  parameter int STORE_DEPTH = lpfr_pkg::STORE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         kind,
  input  logic [7:0]                         data_byte,
  input  logic                               packet_end,
  input  logic [$clog2(STORE_DEPTH)-1:0]     read_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         result_kind,
  output logic [7:0]                         command,
  output logic [$clog2(STORE_DEPTH + 1)-1:0] frame_length,
  output logic [7:0]                         read_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int LW = $clog2(STORE_DEPTH + 1);

  lpfr_pkg::res_ctl_t p_ctl;
  logic [7:0]         p_command;
  logic [LW-1:0]      p_length;
  logic               acc;
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         ram_rdata;
  logic [7:0]         push_data;
  logic [1:0]         q_count;
  logic [2:0]         occupancy;
  logic               rd_acc;
  logic               out_rd;

  // room for the incoming request counting the result in flight
  assign occupancy = {1'b0, q_count} + 3'(p_ctl.vld);
  assign in_ready  = occupancy < 3'(lpfr_pkg::RESQ_DEPTH);
  assign acc       = in_valid && in_ready;

  // request parser and frame state
  lpfr_ctrl #(
    .STORE_DEPTH(STORE_DEPTH),
    .AW         (AW),
    .LW         (LW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .kind      (kind),
    .data_byte (data_byte),
    .packet_end(packet_end),
    .read_index(read_index),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_en     (rd_en),
    .p_ctl     (p_ctl),
    .p_command (p_command),
    .p_length  (p_length)
  );

  // payload store
  lpfr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(data_byte),
    .re   (rd_en),
    .raddr(read_index),
    .rdata(ram_rdata)
  );

  // read data only for in-range read results
  assign push_data = (p_ctl.kind == lpfr_pkg::RK_READ && !p_ctl.oob) ? ram_rdata : 8'd0;

  // result queue
  lpfr_resq #(
    .LW(LW)
  ) u_resq (
    .clk         (clk),
    .rst         (rst),
    .push        (p_ctl.vld),
    .push_kind   (p_ctl.kind),
    .push_command(p_command),
    .push_length (p_length),
    .push_data   (push_data),
    .count       (q_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .command     (command),
    .frame_length(frame_length),
    .read_data   (read_data)
  );

  // checks
  assign rd_acc = acc && kind == lpfr_pkg::KIND_READ;
  assign out_rd = out_valid && result_kind == lpfr_pkg::RK_READ;

  `LPFR_ASSERT_NEVER(a_resq_overflow, p_ctl.vld && q_count == 2'd3 && !out_ready)
  `LPFR_ASSERT_IMPLIES_NEXT(a_read_result, rd_acc, p_ctl.vld && p_ctl.kind == lpfr_pkg::RK_READ)
  `LPFR_ASSERT_IMPLIES(a_read_fields, out_rd, command == 8'd0 && frame_length == '0)

endmodule
